>>> hw/rtl/plst_pkg.sv
`default_nettype none
package plst_pkg;
	typedef enum logic [2:0] {
		CMD_ACQUIRE = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_LOOKUP  = 3'd2,
		CMD_LOAD    = 3'd3,
		CMD_EVICT   = 3'd4,
		CMD_UNLOAD  = 3'd5
	} cmd_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_BUSY      = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_COUNT_ERR = 3'd4;

	localparam int FREED_W = 24;
	localparam logic [FREED_W-1:0] FREED_MAX = '1;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture the command word
		logic exec;       // run a single-slot command
		logic scan_clear; // start a new evict pass
		logic scan_step;  // examine one slot
		logic evict_best; // remove the pass winner
		logic finish_ev;  // write evict result
		logic emit;       // present result
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic is_evict;
		logic scan_last;
		logic have_best;
		logic need_more;
	} stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/plst_ctrl.sv
`default_nettype none
module plst_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output plst_pkg::ctrl_t     ctrl,
	input  wire plst_pkg::stat_t stat
);
	typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_PICK, S_DONE} state_t;
	state_t state_q;

	always_comb begin
		ctrl = '0;
		ctrl.latch = start && !busy;
		unique case (state_q)
			S_IDLE: ;
			S_DECODE: begin
				if (stat.is_evict) begin
					ctrl.scan_clear = 1'b1;
					// nothing to free: result is written straight away
					if (!stat.need_more)
						ctrl.finish_ev = 1'b1;
				end else begin
					ctrl.exec = 1'b1;
					ctrl.emit = 1'b1;
				end
			end
			S_SCAN: ctrl.scan_step = 1'b1;
			S_PICK: begin
				if (stat.have_best && stat.need_more) begin
					ctrl.evict_best = 1'b1;
					ctrl.scan_clear = 1'b1;
				end else
					ctrl.finish_ev = 1'b1;
			end
			S_DONE: ctrl.emit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_DECODE;
					busy <= 1'b1;
				end
				S_DECODE: begin
					if (stat.is_evict)
						state_q <= stat.need_more ? S_SCAN : S_DONE;
					else begin
						state_q <= S_IDLE;
						busy <= 1'b0;
					end
				end
				S_SCAN: if (stat.scan_last) state_q <= S_PICK;
				S_PICK: state_q <= (stat.have_best && stat.need_more) ? S_SCAN : S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !busy) else $error("busy in idle");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> !ctrl.emit) else $error("double result");
	a_start_go: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start lost");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/plst_dp.sv
`default_nettype none
module plst_dp #(
	parameter int SLOTS = 16,
	parameter int STAMP_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire plst_pkg::ctrl_t ctrl,
	output plst_pkg::stat_t      stat,
	input  wire logic [2:0]      command,
	input  wire logic [3:0]      slot_id,
	input  wire logic [15:0]     new_version,
	input  wire logic [19:0]     size_mb,
	input  wire logic [23:0]     needed_mb,
	output logic                 strobe,
	output logic [2:0]           status,
	output logic                 found,
	output logic [15:0]          version_out,
	output logic [7:0]           ref_count_out,
	output logic [23:0]          freed_mb,
	output logic [4:0]           evicted_count
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0]      valid_q;
	logic [7:0]            refs_q  [SLOTS];
	logic [STAMP_BITS-1:0] stamp_q [SLOTS];
	logic [19:0]           size_q  [SLOTS];
	logic [15:0]           ver_q   [SLOTS];
	logic [STAMP_BITS-1:0] tick_q;

	logic [2:0]  cmd_q;
	logic [3:0]  id_q;
	logic [15:0] nver_q;
	logic [19:0] nsize_q;
	logic [23:0] need_q;

	logic [IW-1:0]         scan_q;
	logic                  best_v_q;
	logic [IW-1:0]         best_q;
	logic [STAMP_BITS-1:0] best_st_q;
	logic [23:0]           freed_q;
	logic [4:0]            cnt_q;

	logic          inrange;
	logic [IW-1:0] s;
	logic          v;
	logic [24:0]   fsum;
	logic [STAMP_BITS-1:0] tick_nx;

	assign inrange = {28'd0, id_q} < 32'(SLOTS);
	assign s = inrange ? IW'(id_q) : '0;
	assign v = inrange && valid_q[s];
	assign tick_nx = tick_q + 1'b1;
	assign fsum = {5'd0, size_q[best_q]} + {1'b0, freed_q};

	assign stat.is_evict = (cmd_q == plst_pkg::CMD_EVICT);
	assign stat.scan_last = ({{(32-IW){1'b0}}, scan_q} == 32'(SLOTS - 1));
	assign stat.have_best = best_v_q;
	assign stat.need_more = freed_q < need_q;

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q <= command;
			id_q <= slot_id;
			nver_q <= new_version;
			nsize_q <= size_mb;
			need_q <= needed_mb;
			freed_q <= '0;
			cnt_q <= '0;
		end
		if (ctrl.scan_clear) begin
			scan_q <= '0;
			best_v_q <= 1'b0;
		end
		if (ctrl.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (valid_q[scan_q] && refs_q[scan_q] == 8'd0 &&
			    (!best_v_q || stamp_q[scan_q] < best_st_q)) begin
				best_v_q <= 1'b1;
				best_q <= scan_q;
				best_st_q <= stamp_q[scan_q];
			end
		end
		if (ctrl.evict_best) begin
			freed_q <= fsum[24] ? plst_pkg::FREED_MAX : fsum[23:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctrl.exec && cmd_q == plst_pkg::CMD_LOAD && inrange) begin
			if (!v || refs_q[s] == 8'd0) begin
				size_q[s] <= nsize_q;
				ver_q[s] <= nver_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			tick_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				refs_q[i] <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			if (ctrl.evict_best)
				valid_q[best_q] <= 1'b0;
			if (ctrl.exec && inrange) begin
				unique case (cmd_q)
					plst_pkg::CMD_ACQUIRE: if (v) begin
						if (refs_q[s] != 8'hFF) refs_q[s] <= refs_q[s] + 1'b1;
						tick_q <= tick_nx;
						stamp_q[s] <= tick_nx;
					end
					plst_pkg::CMD_RELEASE:
						if (v && refs_q[s] != 8'd0) refs_q[s] <= refs_q[s] - 1'b1;
					plst_pkg::CMD_LOAD: begin
						if (!v) begin
							valid_q[s] <= 1'b1;
							refs_q[s] <= '0;
							stamp_q[s] <= '0;
						end else if (refs_q[s] == 8'd0) begin
							tick_q <= tick_nx;
							stamp_q[s] <= tick_nx;
						end
					end
					plst_pkg::CMD_UNLOAD: if (v) begin
						valid_q[s] <= 1'b0;
						refs_q[s] <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= ctrl.emit;
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish_ev) begin
			status <= stat.need_more ? plst_pkg::ST_EXHAUSTED : plst_pkg::ST_OK;
			found <= 1'b0;
			version_out <= '0;
			ref_count_out <= '0;
			freed_mb <= freed_q;
			evicted_count <= cnt_q;
		end else if (ctrl.exec) begin
			freed_mb <= '0;
			evicted_count <= '0;
			if (cmd_q > plst_pkg::CMD_UNLOAD) begin
				status <= plst_pkg::ST_OK;
				found <= 1'b0;
				version_out <= '0;
				ref_count_out <= '0;
			end else if (cmd_q == plst_pkg::CMD_LOAD && inrange && !v) begin
				status <= plst_pkg::ST_OK;
				found <= 1'b0;
				version_out <= nver_q;
				ref_count_out <= '0;
			end else if (!v) begin
				status <= plst_pkg::ST_NOT_FOUND;
				found <= 1'b0;
				version_out <= '0;
				ref_count_out <= '0;
			end else begin
				found <= 1'b1;
				unique case (cmd_q)
					plst_pkg::CMD_ACQUIRE: begin
						version_out <= ver_q[s];
						if (refs_q[s] == 8'hFF) begin
							status <= plst_pkg::ST_COUNT_ERR;
							ref_count_out <= refs_q[s];
						end else begin
							status <= plst_pkg::ST_OK;
							ref_count_out <= refs_q[s] + 1'b1;
						end
					end
					plst_pkg::CMD_RELEASE: begin
						version_out <= ver_q[s];
						if (refs_q[s] == 8'd0) begin
							status <= plst_pkg::ST_COUNT_ERR;
							ref_count_out <= refs_q[s];
						end else begin
							status <= plst_pkg::ST_OK;
							ref_count_out <= refs_q[s] - 1'b1;
						end
					end
					plst_pkg::CMD_LOAD: begin
						ref_count_out <= refs_q[s];
						if (refs_q[s] != 8'd0) begin
							status <= plst_pkg::ST_BUSY;
							version_out <= ver_q[s];
						end else begin
							status <= plst_pkg::ST_OK;
							version_out <= nver_q;
						end
					end
					plst_pkg::CMD_UNLOAD: begin
						status <= plst_pkg::ST_OK;
						version_out <= ver_q[s];
						ref_count_out <= '0;
					end
					default: begin
						status <= plst_pkg::ST_OK;
						version_out <= ver_q[s];
						ref_count_out <= refs_q[s];
					end
				endcase
			end
		end
	end

`ifndef ASSERT_OFF
	a_evict_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.evict_best |-> (best_v_q && valid_q[best_q] && refs_q[best_q] == 8'd0))
		else $error("evicting unfit slot");
	a_evict_gone: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.evict_best |=> !valid_q[$past(best_q)]) else $error("slot not removed");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish_ev |-> ({27'd0, cnt_q} <= 32'(SLOTS))) else $error("evict count overrun");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/pinned_lru_slot_table_top.sv
`default_nettype none
// Slot table with LRU eviction and reference-count pinning.
// Command channel: a word is taken on a rising edge with start high and
// busy low; busy stays high until the result shows.
// Result channel: strobe is high for exactly one cycle with status, found,
// version_out, ref_count_out, freed_mb and evicted_count; the receiver
// must take it then, it cannot hold the block off.
// Acquire, release, lookup, load and unload are run in the decode state
// and the registered result follows; the next word may be taken in the
// same cycle the result shows, so a new command waits for the last result.
// Evict runs a scan of one slot a cycle over all SLOTS entries, one pass
// per removed slot and a final pass that removes none.
// An evict that needs nothing freed skips the scan.
// The scan shares the single comparator that finds the oldest unpinned
// slot.
// Reset clears all valid bits, counts, stamps and the use tick; sizes and
// versions are written only by load.
module pinned_lru_slot_table_top #(
	parameter int SLOTS = 16,
	parameter int STAMP_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [3:0]  slot_id,
	input  wire logic [15:0] new_version,
	input  wire logic [19:0] size_mb,
	input  wire logic [23:0] needed_mb,
	output logic             strobe,
	output logic [2:0]       status,
	output logic             found,
	output logic [15:0]      version_out,
	output logic [7:0]       ref_count_out,
	output logic [23:0]      freed_mb,
	output logic [4:0]       evicted_count
);
	plst_pkg::ctrl_t ctrl;
	plst_pkg::stat_t stat;

	plst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ctrl(ctrl), .stat(stat)
	);

	plst_dp #(.SLOTS(SLOTS), .STAMP_BITS(STAMP_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.command(command), .slot_id(slot_id), .new_version(new_version),
		.size_mb(size_mb), .needed_mb(needed_mb), .strobe(strobe),
		.status(status), .found(found), .version_out(version_out),
		.ref_count_out(ref_count_out), .freed_mb(freed_mb),
		.evicted_count(evicted_count)
	);
endmodule
`default_nettype wire
